// ----- rtl/ascending_integer_sorter_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the ascending integer sorter
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_MACROS_SVH
`define ASCENDING_INTEGER_SORTER_MACROS_SVH

// Same-cycle implication
`define AIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ais check failed (same cycle)");

// Next-cycle implication
`define AIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ais check failed (next cycle)");

`endif

// ----- rtl/ais_pkg.sv -----
// ---------------------------------------------------------------------------
// ais_pkg
// Constants and types shared by the ascending integer sorter.
// ---------------------------------------------------------------------------
package ais_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Controller states
  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    val_t value;
    logic valid;
    logic lt;
  } cell_link_t;

endpackage

// ----- rtl/ais_if.sv -----
// ---------------------------------------------------------------------------
// ais interfaces
// Valid/ready channels for input items and sorted results.
// ---------------------------------------------------------------------------
interface ais_in_if import ais_pkg::*; ();
  logic valid;
  logic ready;
  val_t value;
  logic last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ais_out_if import ais_pkg::*; ();
  logic valid;
  logic ready;
  val_t sorted_value;
  logic last_out;
  logic overflowed;

  modport source (output valid, output sorted_value, output last_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input overflowed, output ready);
endinterface

// ----- rtl/ais_cell.sv -----
// ---------------------------------------------------------------------------
// ais_cell
// One slot of the sorted chain: holds a value, inserts or shifts left.
// ---------------------------------------------------------------------------
module ais_cell import ais_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  val_t       x,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t self
);

  val_t value_r, value_nxt;
  logic valid_r, valid_nxt;
  logic lt;

  // An empty slot counts as larger than any value
  assign lt = !valid_r || (x < value_r);

  assign self.value = value_r;
  assign self.valid = valid_r;
  assign self.lt    = lt;

  // Choose next contents: take the left neighbor, the new value, or the right
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (lt) begin
        if (left.lt) begin
          value_nxt = left.value;
          valid_nxt = left.valid;
        end else begin
          value_nxt = x;
          valid_nxt = 1'b1;
        end
      end
    end else if (ctrl.shift) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/ais_ctrl.sv -----
// ---------------------------------------------------------------------------
// ais_ctrl
// Collect/drain sequencer with fill count and overflow flag.
// ---------------------------------------------------------------------------
`include "ascending_integer_sorter_macros.svh"

module ais_ctrl import ais_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       last_out,
  output logic       overflowed,
  output cell_ctrl_t ctrl
);

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  logic   flag_r, flag_nxt;
  logic   full;
  logic   in_acc;
  logic   out_acc;

  assign full    = (count_r == CNT_W'(MAX_ITEMS));
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && last_out) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      ST_COLLECT: in_ready  = 1'b1;
      ST_DRAIN:   out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign last_out    = (count_r == CNT_W'(1));
  assign overflowed  = flag_r;
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Count stored values and remember drops
  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (ctrl.insert) count_nxt = count_r + CNT_W'(1);
    if (out_acc)     count_nxt = count_r - CNT_W'(1);
    if (in_acc && full)        flag_nxt = 1'b1;
    if (out_acc && last_out)   flag_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  `AIS_ASSERT_NOW(a_drain_nonempty, state_r == ST_DRAIN, count_r != '0)
  `AIS_ASSERT_NEXT(a_drop_flags, in_acc && full, flag_r)
  `AIS_ASSERT_NEXT(a_run_ends_clean, out_acc && last_out,
                   state_r == ST_COLLECT && count_r == '0 && !flag_r)
  `AIS_ASSERT_NEXT(a_close_starts_drain, in_acc && in_last, out_valid)

endmodule

// ----- rtl/ascending_integer_sorter.sv -----
// ---------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a set of signed integers and emits them in ascending order.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  in_ch   | in  | value[31:0] signed, last                 | valid/ready
//  out_ch  | out | sorted_value[31:0] signed, last_out,     | valid/ready
//          |     | overflowed                               |
//
//  Collect: one value per cycle; a chain of MAX_ITEMS compare cells inserts
//  each value in its sorted slot in the cycle it is accepted, while not full.
//  Drain: after the last item, one result per cycle while out_ready is high,
//  read from the head cell while the chain shifts left; input is held off until
//  the run is out. A set of n items yields min(n, MAX_ITEMS) results.
//  Reset clears the chain's valid bits, fill count, flag and state at once.
//  A stalled output holds the head cell and the chain unchanged.
// ---------------------------------------------------------------------------
module ascending_integer_sorter import ais_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ais_in_if.sink    in_ch,
  ais_out_if.source out_ch
);

  cell_ctrl_t ctrl;
  cell_link_t links [MAX_ITEMS];

  // Sequencer
  ais_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_last    (in_ch.last),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .last_out   (out_ch.last_out),
    .overflowed (out_ch.overflowed),
    .ctrl       (ctrl)
  );

  // Chain of cells, head at index 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = '0;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_link = '0;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    ais_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .x     (in_ch.value),
      .left  (left_link),
      .right (right_link),
      .self  (links[i])
    );
  end

  // Head cell feeds the result
  assign out_ch.sorted_value = links[0].value;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for ascending_integer_sorter
// Streams sets of signed integers into the sorter and checks each sorted run,
// field by field, against a behavioral sorter that tracks accepted input.
// Both channels idle at random. A long output hold-off keeps a run in the block
// while the sender keeps offering items.
// ---------------------------------------------------------------------------
module testbench;
  import ais_pkg::*;

  localparam int   CLK_PERIOD   = 10;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   RANDOM_ITEMS = 40;
  localparam int   TAIL_CYCLES  = 2 * MAX_ITEMS + 8;
  localparam int   REPORT_MAX   = 10;
  localparam val_t VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    val_t value;
    logic last_out;
    logic overflowed;
  } sorted_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ais_in_if  in_ch ();
  ais_out_if out_ch ();

  ascending_integer_sorter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Values of the open set, as the block should hold them
  val_t           held_vals [MAX_ITEMS];
  int             held_count   = 0;
  logic           held_dropped = 1'b0;
  sorted_result_t sorted_expect_q [$];

  int mismatches  = 0;
  int rx_hold_req = 0;
  bit quiet       = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Add one accepted value; on the closing item, sort and queue the run
  function automatic void absorb_item(val_t v, logic closing);
    val_t           key;
    int             i;
    int             j;
    sorted_result_t r;
    if (held_count < MAX_ITEMS) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (closing) begin
      // insertion sort, signed order
      for (i = 1; i < held_count; i++) begin
        key = held_vals[i];
        j   = i;
        while (j > 0 && held_vals[j-1] > key) begin
          held_vals[j] = held_vals[j-1];
          j--;
        end
        held_vals[j] = key;
      end
      for (i = 0; i < held_count; i++) begin
        r.value      = held_vals[i];
        r.last_out   = (i == held_count - 1);
        r.overflowed = held_dropped;
        sorted_expect_q.push_back(r);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endfunction

  // Compare one result transaction with the oldest expectation
  function automatic void score_result(val_t v, logic l, logic o);
    sorted_result_t e;
    if (sorted_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: unexpected result value %0d last_out %b overflowed %b",
                 $time, v, l, o);
      return;
    end
    e = sorted_expect_q.pop_front();
    if (v !== e.value || l !== e.last_out || o !== e.overflowed) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: mismatch: expected value %0d last_out %b overflowed %b",
                 $time, e.value, e.last_out, e.overflowed);
        $display("%0t: mismatch: got value %0d last_out %b overflowed %b",
                 $time, v, l, o);
      end
    end
  endfunction

  // Sample both channels mid-cycle; the transaction completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        absorb_item(in_ch.value, in_ch.last);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        score_result(out_ch.sorted_value, out_ch.last_out, out_ch.overflowed);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Abort a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL ascending_integer_sorter");
    $finish;
  end

  // Offer one item and hold it until accepted; returns at the accepting edge
  task automatic send_item(val_t v, logic closing);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= closing;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
  endtask

  task automatic send_set(val_t vals [$]);
    int i;
    for (i = 0; i < vals.size(); i++)
      send_item(vals[i], i == vals.size() - 1);
  endtask

  function automatic val_t random_value();
    case ($urandom_range(0, 3))
      0: return val_t'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set(int n);
    val_t vals [$];
    int   i;
    for (i = 0; i < n; i++)
      vals.push_back(random_value());
    send_set(vals);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sorted_expect_q.size() != 0);
  endtask

  // Single values at the extremes, mixed signs, duplicates, reverse-sorted and presorted runs
  task automatic test_directed();
    val_t s [$];
    s = '{VAL_MIN};
    send_set(s);
    s = '{VAL_MAX};
    send_set(s);
    s = '{VAL_MAX, VAL_MIN, 0, -1, 1};
    send_set(s);
    s = '{5, 5, -5, 5, -5};
    send_set(s);
    s = '{40, 30, 20, 10, 0, -10};
    send_set(s);
    s = '{-3, -2, -1};
    send_set(s);
    wait_drained();
  endtask

  // Full store, then a closing item that is dropped
  task automatic test_capacity();
    send_random_set(MAX_ITEMS + 1);
    wait_drained();
  endtask

  // Hold the output off long enough that the next set backs up at the input
  task automatic test_backpressure();
    rx_hold_req = 4 * MAX_ITEMS;
    send_random_set(12);
    send_random_set(8);
    send_random_set(3);
    wait_drained();
  endtask

  // Random short sets
  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(1, 12);
      send_random_set(n);
      sent += n;
      if ($urandom_range(0, 4) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming();
    int k;
    quiet = 1'b1;
    for (k = 0; k < 6; k++)
      send_random_set($urandom_range(1, 8));
    send_random_set(2);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_n       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity();
    test_backpressure();
    test_random_sets();
    test_streaming();

    // Let the last run drain, then watch for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && sorted_expect_q.size() == 0) begin
      $display("PASS ascending_integer_sorter");
    end else begin
      $display("FAIL ascending_integer_sorter");
    end
    $finish;
  end

endmodule
